[design/shac_pkg.sv]
// ----------------------------------------------------------------------------
// shac_pkg
// Shared constants, types and round functions for the SHA-256 compression
// block: round constants, initial hash, sigma functions, control struct.
// ----------------------------------------------------------------------------
package shac_pkg;

    localparam int WORD_W  = 32;
    localparam int ROUND_W = 6;
    localparam int SLOT_W  = 4;
    localparam int IDX_W   = 3;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [ROUND_W-1:0] t_round;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [IDX_W-1:0]   t_idx;

    // control from the sequencer to the round datapath
    typedef struct packed {
        logic init_iv;    // reload chaining value with the initial hash
        logic load_vars;  // copy chaining value into a..h
        logic do_round;   // run one compression round
        logic add_back;   // add a..h into the chaining value
    } t_ctrl;

    localparam t_word ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // upper-case sigma 0 on working variable a
    function automatic t_word big_sig0(input t_word x);
        big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // upper-case sigma 1 on working variable e
    function automatic t_word big_sig1(input t_word x);
        big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // lower-case sigma 0 for schedule expansion
    function automatic t_word small_sig0(input t_word x);
        small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // lower-case sigma 1 for schedule expansion
    function automatic t_word small_sig1(input t_word x);
        small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

[design/shac_sched.sv]
// ----------------------------------------------------------------------------
// shac_sched
// Sixteen-word schedule window held in a synchronous memory with two read
// ports and one write port. Collects message words and expands the schedule
// in place, one word per round.
// ----------------------------------------------------------------------------
module shac_sched (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  shac_pkg::t_slot i_wr_slot,
    input  shac_pkg::t_word i_wr_data,
    input  logic            i_active,
    input  shac_pkg::t_round i_round,
    input  shac_pkg::t_round i_issue,
    output shac_pkg::t_word o_w
);
    import shac_pkg::*;

    t_word mem [0:15];
    t_word r_rd_a;
    t_word r_rd_b;
    t_word r_w1;
    t_word r_w2;
    t_word r_w16;

    t_slot addr_a;
    t_slot addr_b;
    t_slot issue_lo;
    t_word w_calc;
    logic  expanding;

    // read addresses for the round after this one
    assign issue_lo  = i_issue[SLOT_W-1:0];
    assign addr_a    = (i_issue < t_round'(16)) ? issue_lo : issue_lo - t_slot'(7);
    assign addr_b    = issue_lo + t_slot'(1);
    assign expanding = i_active && (i_round >= t_round'(16));

    // schedule word for this round
    assign w_calc = small_sig1(r_w2) + r_rd_a + small_sig0(r_rd_b) + r_w16;
    assign o_w    = expanding ? w_calc : r_rd_a;

    // window memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (expanding) begin
            mem[i_round[SLOT_W-1:0]] <= w_calc;
        end else if (i_wr_en) begin
            mem[i_wr_slot] <= i_wr_data;
        end
        r_rd_a <= mem[addr_a];
        r_rd_b <= mem[addr_b];
    end

    // recent schedule words kept beside the memory
    always_ff @(posedge i_clk) begin
        if (i_active) begin
            r_w1  <= o_w;
            r_w2  <= r_w1;
            r_w16 <= r_rd_b;
        end
    end

endmodule

[design/shac_core.sv]
// ----------------------------------------------------------------------------
// shac_core
// Round datapath: working variables a..h, one round per cycle, and the
// chaining value with its final add-back and digest word select.
// ----------------------------------------------------------------------------
module shac_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  shac_pkg::t_ctrl  i_ctrl,
    input  shac_pkg::t_round i_round,
    input  shac_pkg::t_word  i_w,
    input  shac_pkg::t_idx   i_idx,
    output shac_pkg::t_word  o_digest
);
    import shac_pkg::*;

    t_word r_v [0:7];
    t_word r_h [0:7];
    t_word t1;
    t_word t2;
    t_word ch;
    t_word maj;

    // round function
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + big_sig1(r_v[4]) + ch + ROUND_K[i_round] + i_w;
    assign t2  = big_sig0(r_v[0]) + maj;

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_vars) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_ctrl.do_round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.init_iv) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= INIT_HASH[i];
            end
        end else if (i_ctrl.add_back) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    assign o_digest = r_h[i_idx];

endmodule

[design/sha256_block_compression.sv]
// ----------------------------------------------------------------------------
// sha256_block_compression
// SHA-256 compression over a stream of padded 32-bit message words.
// ----------------------------------------------------------------------------
// Sixteen big-endian words make a block; tuser high on a word starts a new
// message and reloads the initial hash. After the sixteenth word the block
// runs 64 rounds, one per cycle, with the schedule expanded in a 16-word
// memory, then an add-back step, and then sends the eight chaining words
// H0..H7 with tlast on H7. Words of the next block are taken while the digest
// drains, except a start word or a block-completing word, which wait until the
// last digest word is transferred; no word is taken during rounds or add-back.
// ----------------------------------------------------------------------------
module sha256_block_compression (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] message_word
    input  logic [0:0]  i_s_tuser,   // [0] start_message
    // digest words
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        o_m_tlast    // last_word
);
    import shac_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0] r_state, n_state;
    t_round     r_round, n_round;
    t_slot      r_count, n_count;
    t_idx       r_idx, n_idx;

    logic   in_xfer;
    logic   out_xfer;
    logic   start;
    logic   block_done;
    t_slot  wr_slot;
    t_round issue;
    t_ctrl  ctrl;
    t_word  w;
    t_word  digest;

    assign start      = i_s_tuser[0];
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign out_xfer   = o_m_tvalid && i_m_tready;
    assign wr_slot    = start ? t_slot'(0) : r_count;
    assign block_done = in_xfer && !start && (r_count == t_slot'(15));

    // input ready: always when idle, during drain only for words that neither start a message nor complete a block
    always_comb begin
        case (r_state)
            ST_IDLE:  o_s_tready = 1'b1;
            ST_DRAIN: o_s_tready = !start && (r_count != t_slot'(15));
            default:  o_s_tready = 1'b0;
        endcase
    end

    // round whose schedule reads are issued this cycle
    assign issue = (r_state == ST_ROUND) ? r_round + t_round'(1) : t_round'(0);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_count = r_count;
        n_idx   = r_idx;
        ctrl    = '0;
        if (in_xfer) begin
            n_count      = wr_slot + t_slot'(1);
            ctrl.init_iv = start;
        end
        case (r_state)
            ST_IDLE: begin
                if (block_done) begin
                    ctrl.load_vars = 1'b1;
                    n_round        = '0;
                    n_state        = ST_ROUND;
                end
            end
            ST_ROUND: begin
                ctrl.do_round = 1'b1;
                n_round       = r_round + t_round'(1);
                if (r_round == t_round'(63)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                ctrl.add_back = 1'b1;
                n_idx         = '0;
                n_state       = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (out_xfer) begin
                    n_idx = r_idx + t_idx'(1);
                    if (r_idx == t_idx'(7)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    // schedule window memory
    shac_sched u_sched (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer),
        .i_wr_slot (wr_slot),
        .i_wr_data (i_s_tdata),
        .i_active  (ctrl.do_round),
        .i_round   (r_round),
        .i_issue   (issue),
        .o_w       (w)
    );

    // round datapath and chaining value
    shac_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_round  (r_round),
        .i_w      (w),
        .i_idx    (r_idx),
        .o_digest (digest)
    );

    // digest output
    assign o_m_tvalid = (r_state == ST_DRAIN);
    assign o_m_tdata  = {5'd0, r_idx, digest};
    assign o_m_tlast  = (r_idx == t_idx'(7));

endmodule
